### hw/rtl/tlx_pkg.sv
// ----------------------------------------------------------------------------
// tlx_pkg
// shared constants, token codes and character classes for the token lexer
// ----------------------------------------------------------------------------
package tlx_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 24;
  localparam int unsigned LINE_BITS_DEF   = 16;
  localparam int unsigned LENGTH_BITS_DEF = 16;

  localparam int unsigned KIND_W  = 5;
  localparam int unsigned ERR_W   = 2;
  localparam int unsigned SLOTS   = 4;
  localparam int unsigned WIN_W   = 56;

  // token kinds
  localparam logic [KIND_W-1:0] K_END    = 5'd0;
  localparam logic [KIND_W-1:0] K_INT    = 5'd1;
  localparam logic [KIND_W-1:0] K_IDENT  = 5'd2;
  localparam logic [KIND_W-1:0] K_FUNC   = 5'd3;
  localparam logic [KIND_W-1:0] K_VAR    = 5'd4;
  localparam logic [KIND_W-1:0] K_IF     = 5'd5;
  localparam logic [KIND_W-1:0] K_ELSE   = 5'd6;
  localparam logic [KIND_W-1:0] K_WHILE  = 5'd7;
  localparam logic [KIND_W-1:0] K_FOR    = 5'd8;
  localparam logic [KIND_W-1:0] K_RETURN = 5'd9;
  localparam logic [KIND_W-1:0] K_PRINT  = 5'd10;
  localparam logic [KIND_W-1:0] K_PLUS   = 5'd11;
  localparam logic [KIND_W-1:0] K_MINUS  = 5'd12;
  localparam logic [KIND_W-1:0] K_STAR   = 5'd13;
  localparam logic [KIND_W-1:0] K_SLASH  = 5'd14;
  localparam logic [KIND_W-1:0] K_PCT    = 5'd15;
  localparam logic [KIND_W-1:0] K_LPAR   = 5'd16;
  localparam logic [KIND_W-1:0] K_RPAR   = 5'd17;
  localparam logic [KIND_W-1:0] K_LBRACE = 5'd18;
  localparam logic [KIND_W-1:0] K_RBRACE = 5'd19;
  localparam logic [KIND_W-1:0] K_SEMI   = 5'd20;
  localparam logic [KIND_W-1:0] K_COMMA  = 5'd21;
  localparam logic [KIND_W-1:0] K_NE     = 5'd22;
  localparam logic [KIND_W-1:0] K_NOT    = 5'd23;
  localparam logic [KIND_W-1:0] K_EQ     = 5'd24;
  localparam logic [KIND_W-1:0] K_ASSIGN = 5'd25;
  localparam logic [KIND_W-1:0] K_LE     = 5'd26;
  localparam logic [KIND_W-1:0] K_LT     = 5'd27;
  localparam logic [KIND_W-1:0] K_GE     = 5'd28;
  localparam logic [KIND_W-1:0] K_GT     = 5'd29;
  localparam logic [KIND_W-1:0] K_AND    = 5'd30;
  localparam logic [KIND_W-1:0] K_OR     = 5'd31;

  // error codes
  localparam logic [ERR_W-1:0] E_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] E_AMP     = 2'd1;
  localparam logic [ERR_W-1:0] E_BAR     = 2'd2;
  localparam logic [ERR_W-1:0] E_UNKNOWN = 2'd3;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // keyword spellings, right aligned in the window
  localparam logic [WIN_W-1:0] KW_TEXT [8] = '{
    56'h66756E63, 56'h766172, 56'h6966, 56'h656C7365,
    56'h7768696C65, 56'h666F72, 56'h72657475726E, 56'h7072696E74
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_held(input logic [7:0] c);
    return (c == 8'h21) || (c == 8'h3D) || (c == 8'h3C) || (c == 8'h3E) ||
           (c == 8'h26) || (c == 8'h7C);
  endfunction

  function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    k = K_END;
    case (c)
      8'h2B: k = K_PLUS;
      8'h2D: k = K_MINUS;
      8'h2A: k = K_STAR;
      8'h25: k = K_PCT;
      8'h28: k = K_LPAR;
      8'h29: k = K_RPAR;
      8'h7B: k = K_LBRACE;
      8'h7D: k = K_RBRACE;
      8'h3B: k = K_SEMI;
      8'h2C: k = K_COMMA;
      default: k = K_END;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
    logic [KIND_W-1:0] k;
    k = K_END;
    if (c == 8'h3D) begin
      case (h)
        8'h21: k = K_NE;
        8'h3D: k = K_EQ;
        8'h3C: k = K_LE;
        8'h3E: k = K_GE;
        default: k = K_END;
      endcase
    end
    if ((h == 8'h26) && (c == 8'h26)) k = K_AND;
    if ((h == 8'h7C) && (c == 8'h7C)) k = K_OR;
    return k;
  endfunction

  // parallel compare of the identifier window against all keywords
  function automatic logic [KIND_W-1:0] word_kind(input logic [WIN_W-1:0] win,
                                                  input logic short_word);
    logic [KIND_W-1:0] k;
    k = K_IDENT;
    if (short_word) begin
      for (int i = 0; i < 8; i++) begin
        if (win == KW_TEXT[i]) k = K_FUNC + KIND_W'(i);
      end
    end
    return k;
  endfunction

endpackage

### hw/rtl/tlx_front.sv
// ----------------------------------------------------------------------------
// tlx_front
// scanner state machine: takes one byte per cycle unless the queue is full, builds a result bundle
// ----------------------------------------------------------------------------
module tlx_front #(
  parameter int unsigned OFFSET_BITS = tlx_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LINE_BITS   = tlx_pkg::LINE_BITS_DEF,
  parameter int unsigned LENGTH_BITS = tlx_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] source_byte_i,
  input  logic       byte_present_i,
  input  logic       end_of_source_i,
  output logic       push_o,
  output logic [tlx_pkg::SLOTS+tlx_pkg::SLOTS*
                (tlx_pkg::KIND_W+tlx_pkg::ERR_W+LINE_BITS+OFFSET_BITS+LENGTH_BITS)-1:0]
                     push_data_o,
  input  logic       full_i
);
  import tlx_pkg::*;

  localparam int unsigned SLOT_W = KIND_W + ERR_W + LINE_BITS + OFFSET_BITS + LENGTH_BITS;

  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_INT   = 4'd1;
  localparam logic [3:0] M_IDENT = 4'd2;
  localparam logic [3:0] M_SLASH = 4'd3;
  localparam logic [3:0] M_LINEC = 4'd4;
  localparam logic [3:0] M_BLOCK = 4'd5;
  localparam logic [3:0] M_BSTAR = 4'd6;
  localparam logic [3:0] M_HELD  = 4'd7;
  localparam logic [3:0] M_DROP  = 4'd8;

  logic [3:0]             mode_q, mode_d;
  logic [7:0]             held_q, held_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [OFFSET_BITS-1:0] pstart_q, pstart_d;
  logic [LINE_BITS-1:0]   pline_q, pline_d;
  logic [LENGTH_BITS-1:0] plen_q, plen_d;
  logic [WIN_W-1:0]       win_q, win_d;

  logic [SLOTS-1:0]             mask;
  logic [SLOTS-1:0][SLOT_W-1:0] slots;
  logic                         accept;

  function automatic logic [SLOT_W-1:0] pack(input logic [KIND_W-1:0] k,
                                              input logic [ERR_W-1:0] e,
                                              input logic [LINE_BITS-1:0] l,
                                              input logic [OFFSET_BITS-1:0] s,
                                              input logic [LENGTH_BITS-1:0] n);
    return {k, e, l, s, n};
  endfunction

  assign accept     = in_valid_i & ~full_i;
  assign in_stall_o = full_i;

  always_comb begin
    logic [7:0]       c;
    logic             st;
    logic [KIND_W-1:0] k;
    logic [KIND_W-1:0] pk;
    c      = source_byte_i;
    st     = 1'b0;
    k      = K_END;
    pk     = K_END;
    mode_d   = mode_q;
    held_d   = held_q;
    line_d   = line_q;
    off_d    = off_q;
    pstart_d = pstart_q;
    pline_d  = pline_q;
    plen_d   = plen_q;
    win_d    = win_q;
    mask     = '0;
    slots    = '0;

    // byte: finish or extend the pending token (slot 0), start a new one (slot 1)
    if (byte_present_i) begin
      case (mode_q)
        M_INT: begin
          if (is_digit(c)) begin
            if (~&plen_d) plen_d = plen_d + 1'b1;
          end else begin
            mask[0]  = 1'b1;
            slots[0] = pack(K_INT, E_NONE, pline_q, pstart_q, plen_q);
            st = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_word(c)) begin
            if (~&plen_d) plen_d = plen_d + 1'b1;
            win_d = {win_q[WIN_W-9:0], c};
          end else begin
            mask[0]  = 1'b1;
            slots[0] = pack(word_kind(win_q, plen_q <= LENGTH_BITS'(6)), E_NONE,
                            pline_q, pstart_q, plen_q);
            st = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == 8'h2F) mode_d = M_LINEC;
          else if (c == 8'h2A) mode_d = M_BLOCK;
          else begin
            mask[0]  = 1'b1;
            slots[0] = pack(K_SLASH, E_NONE, pline_q, pstart_q, LENGTH_BITS'(1));
            st = 1'b1;
          end
        end
        M_LINEC: begin
          if (c == CH_LF) mode_d = M_IDLE;
        end
        M_BLOCK: begin
          if (c == 8'h2A) mode_d = M_BSTAR;
        end
        M_BSTAR: begin
          if (c == 8'h2F) mode_d = M_IDLE;
          else if (c != 8'h2A) mode_d = M_BLOCK;
        end
        M_HELD: begin
          pk      = pair_kind(held_q, c);
          mask[0] = 1'b1;
          if (pk != K_END) begin
            slots[0] = pack(pk, E_NONE, pline_q, pstart_q, LENGTH_BITS'(2));
            mode_d   = M_IDLE;
          end else begin
            case (held_q)
              8'h21: begin
                slots[0] = pack(K_NOT, E_NONE, pline_q, pstart_q, LENGTH_BITS'(1));
                st = 1'b1;
              end
              8'h3D: begin
                slots[0] = pack(K_ASSIGN, E_NONE, pline_q, pstart_q, LENGTH_BITS'(1));
                st = 1'b1;
              end
              8'h3C: begin
                slots[0] = pack(K_LT, E_NONE, pline_q, pstart_q, LENGTH_BITS'(1));
                st = 1'b1;
              end
              8'h3E: begin
                slots[0] = pack(K_GT, E_NONE, pline_q, pstart_q, LENGTH_BITS'(1));
                st = 1'b1;
              end
              8'h26: begin
                slots[0] = pack(K_END, E_AMP, pline_q, pstart_q, LENGTH_BITS'(1));
                mode_d   = M_DROP;
              end
              default: begin
                slots[0] = pack(K_END, E_BAR, pline_q, pstart_q, LENGTH_BITS'(1));
                mode_d   = M_DROP;
              end
            endcase
          end
        end
        M_DROP: begin
        end
        default: st = 1'b1;
      endcase

      if (st) begin
        mode_d = M_IDLE;
        k      = single_kind(c);
        if (is_space(c)) begin
        end else if (is_digit(c)) begin
          mode_d = M_INT;
          pstart_d = off_q; pline_d = line_q; plen_d = LENGTH_BITS'(1);
        end else if (is_alpha(c) || (c == CH_UNDER)) begin
          mode_d = M_IDENT;
          pstart_d = off_q; pline_d = line_q; plen_d = LENGTH_BITS'(1);
          win_d  = WIN_W'(c);
        end else if (c == 8'h2F) begin
          mode_d = M_SLASH;
          pstart_d = off_q; pline_d = line_q; plen_d = LENGTH_BITS'(1);
        end else if (k != K_END) begin
          mask[1]  = 1'b1;
          slots[1] = pack(k, E_NONE, line_q, off_q, LENGTH_BITS'(1));
        end else if (is_held(c)) begin
          mode_d = M_HELD;
          held_d = c;
          pstart_d = off_q; pline_d = line_q; plen_d = LENGTH_BITS'(1);
        end else begin
          mask[1]  = 1'b1;
          slots[1] = pack(K_END, E_UNKNOWN, line_q, off_q, LENGTH_BITS'(1));
          mode_d   = M_DROP;
        end
      end

      if ((c == CH_LF) && ~&line_q) line_d = line_q + 1'b1;
      if (~&off_q) off_d = off_q + 1'b1;
    end

    // end of source: flush pending token (slot 2), then END (slot 3), then restart
    if (end_of_source_i) begin
      case (mode_d)
        M_INT: begin
          mask[2]  = 1'b1;
          slots[2] = pack(K_INT, E_NONE, pline_d, pstart_d, plen_d);
        end
        M_IDENT: begin
          mask[2]  = 1'b1;
          slots[2] = pack(word_kind(win_d, plen_d <= LENGTH_BITS'(6)), E_NONE,
                          pline_d, pstart_d, plen_d);
        end
        M_SLASH: begin
          mask[2]  = 1'b1;
          slots[2] = pack(K_SLASH, E_NONE, pline_d, pstart_d, LENGTH_BITS'(1));
        end
        M_HELD: begin
          mask[2] = 1'b1;
          case (held_d)
            8'h21: slots[2] = pack(K_NOT, E_NONE, pline_d, pstart_d, LENGTH_BITS'(1));
            8'h3D: slots[2] = pack(K_ASSIGN, E_NONE, pline_d, pstart_d, LENGTH_BITS'(1));
            8'h3C: slots[2] = pack(K_LT, E_NONE, pline_d, pstart_d, LENGTH_BITS'(1));
            8'h3E: slots[2] = pack(K_GT, E_NONE, pline_d, pstart_d, LENGTH_BITS'(1));
            8'h26: slots[2] = pack(K_END, E_AMP, pline_d, pstart_d, LENGTH_BITS'(1));
            default: slots[2] = pack(K_END, E_BAR, pline_d, pstart_d, LENGTH_BITS'(1));
          endcase
        end
        default: begin
        end
      endcase
      mask[3]  = 1'b1;
      slots[3] = pack(K_END, E_NONE, line_d, off_d, '0);
      mode_d   = M_IDLE;
      held_d   = '0;
      line_d   = LINE_BITS'(1);
      off_d    = '0;
      pstart_d = '0;
      pline_d  = LINE_BITS'(1);
      plen_d   = '0;
      win_d    = '0;
    end
  end

  assign push_o      = accept & (|mask);
  assign push_data_o = {mask, slots};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      held_q   <= '0;
      line_q   <= LINE_BITS'(1);
      off_q    <= '0;
      pstart_q <= '0;
      pline_q  <= LINE_BITS'(1);
      plen_q   <= '0;
      win_q    <= '0;
    end else if (accept) begin
      mode_q   <= mode_d;
      held_q   <= held_d;
      line_q   <= line_d;
      off_q    <= off_d;
      pstart_q <= pstart_d;
      pline_q  <= pline_d;
      plen_q   <= plen_d;
      win_q    <= win_d;
    end
  end

endmodule

### hw/rtl/tlx_fifo.sv
// ----------------------------------------------------------------------------
// tlx_fifo
// two-entry queue of result bundles between scanner and output sequencer
// ----------------------------------------------------------------------------
module tlx_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             avail_o,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign avail_o    = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && !avail_o))
    else $error("queue overflow or underflow");

endmodule

### hw/rtl/tlx_back.sv
// ----------------------------------------------------------------------------
// tlx_back
// output sequencer: hands out the results of one bundle, one per unstalled cycle
// ----------------------------------------------------------------------------
module tlx_back #(
  parameter int unsigned OFFSET_BITS = tlx_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LINE_BITS   = tlx_pkg::LINE_BITS_DEF,
  parameter int unsigned LENGTH_BITS = tlx_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        avail_i,
  input  logic [tlx_pkg::SLOTS+tlx_pkg::SLOTS*
                (tlx_pkg::KIND_W+tlx_pkg::ERR_W+LINE_BITS+OFFSET_BITS+LENGTH_BITS)-1:0]
                                      pop_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tlx_pkg::KIND_W-1:0]  token_kind_o,
  output logic [tlx_pkg::ERR_W-1:0]   error_code_o,
  output logic [LINE_BITS-1:0]        token_line_o,
  output logic [OFFSET_BITS-1:0]      token_start_o,
  output logic [LENGTH_BITS-1:0]      token_length_o,
  output logic                        last_result_o
);
  import tlx_pkg::*;

  localparam int unsigned SLOT_W = KIND_W + ERR_W + LINE_BITS + OFFSET_BITS + LENGTH_BITS;

  logic [SLOTS-1:0]             mask_q, mask_d;
  logic [SLOTS-1:0][SLOT_W-1:0] slots_q;
  logic [SLOTS-1:0]             sel;
  logic [SLOT_W-1:0]            cur;
  logic                         out_take;

  // lowest pending slot goes first
  always_comb begin
    sel = '0;
    cur = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel    = '0;
        sel[i] = 1'b1;
        cur    = slots_q[i];
      end
    end
  end

  assign out_valid_o   = |mask_q;
  assign last_result_o = (mask_q & ~sel) == '0;
  assign {token_kind_o, error_code_o, token_line_o, token_start_o, token_length_o} = cur;

  assign out_take = out_valid_o & ~out_stall_i;
  assign pop_o    = avail_i & (~out_valid_o | (out_take & last_result_o));

  always_comb begin
    mask_d = mask_q;
    if (out_take) mask_d = mask_q & ~sel;
    if (pop_o) mask_d = pop_data_i[SLOTS*SLOT_W +: SLOTS];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) slots_q <= pop_data_i[SLOTS*SLOT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mask_q <= '0;
    else mask_q <= mask_d;
  end

  a_keep_going: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !last_result_o |=> out_valid_o)
    else $error("bundle dropped before its last result");

  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != E_NONE |->
      token_kind_o == K_END && token_length_o == LENGTH_BITS'(1))
    else $error("malformed error result");

  a_one_gone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !last_result_o |=> $countones(mask_q) == $countones($past(mask_q)) - 1)
    else $error("more than one result retired");

endmodule

### hw/rtl/token_lexer.sv
// ----------------------------------------------------------------------------
// token_lexer
// streaming lexer: source bytes in, tokens with kind, line, start and length out
// ----------------------------------------------------------------------------
// usage:
//   input transaction: in_valid_i high and in_stall_o low; it carries one
//   source byte (byte_present_i) and/or the end-of-source mark.
//   output transaction: out_valid_o high and out_stall_i low; it carries one
//   token, last_result_o marks the final token caused by an input transaction.
//   an input transaction causes zero to three tokens.
// path: a token completed by an accepted byte goes from the scanner into the
//   registered queue, then into the output register, before it appears.
// throughput: one byte per cycle while each byte causes at most one token
//   and the output is not stalled; a byte causing more holds the sequencer
//   until the single output port, one token per cycle, has retired them all.
// the scanner stalls only when the two-entry bundle queue is full, so it
//   keeps taking bytes while a finished token waits at a stalled output.
// reset: scanner restarts at line 1, offset 0, queue and output empty.
// ----------------------------------------------------------------------------
module token_lexer #(
  parameter int unsigned OFFSET_BITS = tlx_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LINE_BITS   = tlx_pkg::LINE_BITS_DEF,
  parameter int unsigned LENGTH_BITS = tlx_pkg::LENGTH_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 source_byte_i,
  input  logic                       byte_present_i,
  input  logic                       end_of_source_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tlx_pkg::KIND_W-1:0] token_kind_o,
  output logic [tlx_pkg::ERR_W-1:0]  error_code_o,
  output logic [LINE_BITS-1:0]       token_line_o,
  output logic [OFFSET_BITS-1:0]     token_start_o,
  output logic [LENGTH_BITS-1:0]     token_length_o,
  output logic                       last_result_o
);
  import tlx_pkg::*;

  // one bundle: four result slots plus a mask of the slots in use
  localparam int unsigned BUND_W =
    SLOTS + SLOTS * (KIND_W + ERR_W + LINE_BITS + OFFSET_BITS + LENGTH_BITS);

  logic              push, full, pop, avail;
  logic [BUND_W-1:0] push_data, pop_data;

  // scanner: classifies each byte and builds the bundle of tokens it causes
  tlx_front #(
    .OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS), .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .source_byte_i, .byte_present_i,
    .end_of_source_i, .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  // decouples scanner from a stalled output
  tlx_fifo #(.WIDTH(BUND_W)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .avail_o(avail), .pop_data_o(pop_data)
  );

  // output sequencer: retires bundle slots in order
  tlx_back #(
    .OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS), .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk_i, .rst_ni, .avail_i(avail), .pop_data_i(pop_data), .pop_o(pop),
    .out_valid_o, .out_stall_i, .token_kind_o, .error_code_o, .token_line_o,
    .token_start_o, .token_length_o, .last_result_o
  );

endmodule

### test/token_lexer_checker.sv
// ----------------------------------------------------------------------------
// token_lexer_checker
// watches both channels, predicts tokens per accepted input and compares them
// ----------------------------------------------------------------------------
module token_lexer_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [7:0]                 source_byte_i,
  input  logic                       byte_present_i,
  input  logic                       end_of_source_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [tlx_pkg::KIND_W-1:0] token_kind_i,
  input  logic [tlx_pkg::ERR_W-1:0]  error_code_i,
  input  logic [15:0]                token_line_i,
  input  logic [23:0]                token_start_i,
  input  logic [15:0]                token_length_i,
  input  logic                       last_result_i,
  output int                         fail_count_o,
  output int                         pending_tokens_o
);
  import tlx_pkg::*;

  typedef enum logic [3:0] {
    SC_IDLE, SC_INT, SC_IDENT, SC_SLASH, SC_LINEC, SC_BLOCK, SC_BSTAR, SC_HELD,
    SC_DROP
  } scan_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  err;
    logic [15:0]       line;
    logic [23:0]       start;
    logic [15:0]       len;
    logic              last;
  } token_t;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  token_t      token_queue[$];
  token_t      step_tokens[$];
  scan_e       mode;
  logic [7:0]  held_ch;
  logic [15:0] line_cnt, tok_line, tok_len;
  logic [23:0] offset, tok_start;
  logic [55:0] window;
  int          fails;

  assign fail_count_o     = fails;
  assign pending_tokens_o = token_queue.size();

  function automatic logic digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  task automatic push_token(logic [KIND_W-1:0] k, logic [ERR_W-1:0] e, logic [15:0] l,
                            logic [23:0] s, logic [15:0] n);
    token_t t;
    t = '{k, e, l, s, n, 1'b0};
    step_tokens = {step_tokens, t};
  endtask

  task automatic clear_scan();
    mode = SC_IDLE; held_ch = '0; line_cnt = 16'd1; offset = '0;
    tok_start = '0; tok_line = 16'd1; tok_len = '0; window = '0;
  endtask

  task automatic open_token(logic [7:0] c);
    logic [KIND_W-1:0] k;
    k = K_END;
    case (c)
      "+": k = K_PLUS;  "-": k = K_MINUS;  "*": k = K_STAR;  "%": k = K_PCT;
      "(": k = K_LPAR;  ")": k = K_RPAR;   "{": k = K_LBRACE; "}": k = K_RBRACE;
      ";": k = K_SEMI;  ",": k = K_COMMA;
      default: k = K_END;
    endcase
    mode = SC_IDLE;
    tok_start = offset; tok_line = line_cnt; tok_len = 16'd1;
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
    if (digit_c(c)) mode = SC_INT;
    else if (alpha_c(c) || c == CH_UNDER) begin
      mode = SC_IDENT; window = {48'd0, c};
    end else if (c == CH_SLASH) mode = SC_SLASH;
    else if (k != K_END) push_token(k, E_NONE, line_cnt, offset, 16'd1);
    else if (c == CH_BANG || c == CH_EQ || c == CH_LT || c == CH_GT ||
             c == CH_AMP || c == CH_BAR) begin
      mode = SC_HELD; held_ch = c;
    end else begin
      push_token(K_END, E_UNKNOWN, line_cnt, offset, 16'd1);
      mode = SC_DROP;
    end
  endtask

  task automatic close_word();
    logic [KIND_W-1:0] k;
    logic [55:0] kw [8];
    k = K_IDENT;
    kw = '{56'h66756E63, 56'h766172, 56'h6966, 56'h656C7365, 56'h7768696C65,
           56'h666F72, 56'h72657475726E, 56'h7072696E74};
    if (tok_len <= 16'd6)
      for (int i = 0; i < 8; i++) if (window == kw[i]) k = K_FUNC + KIND_W'(i);
    push_token(k, E_NONE, tok_line, tok_start, tok_len);
  endtask

  // lone held operator: single operator, or an error for & and |
  task automatic close_held();
    mode = SC_IDLE;
    case (held_ch)
      CH_BANG: push_token(K_NOT, E_NONE, tok_line, tok_start, 16'd1);
      CH_EQ:   push_token(K_ASSIGN, E_NONE, tok_line, tok_start, 16'd1);
      CH_LT:   push_token(K_LT, E_NONE, tok_line, tok_start, 16'd1);
      CH_GT:   push_token(K_GT, E_NONE, tok_line, tok_start, 16'd1);
      CH_AMP: begin
        push_token(K_END, E_AMP, tok_line, tok_start, 16'd1); mode = SC_DROP;
      end
      default: begin
        push_token(K_END, E_BAR, tok_line, tok_start, 16'd1); mode = SC_DROP;
      end
    endcase
  endtask

  task automatic scan_byte(logic [7:0] c);
    logic [KIND_W-1:0] pk;
    pk = K_END;
    if (c == CH_EQ) begin
      if (held_ch == CH_BANG) pk = K_NE;
      else if (held_ch == CH_EQ) pk = K_EQ;
      else if (held_ch == CH_LT) pk = K_LE;
      else if (held_ch == CH_GT) pk = K_GE;
    end
    if (held_ch == CH_AMP && c == CH_AMP) pk = K_AND;
    if (held_ch == CH_BAR && c == CH_BAR) pk = K_OR;
    case (mode)
      SC_INT:
        if (digit_c(c)) begin
          if (tok_len != 16'hFFFF) tok_len++;
        end else begin
          push_token(K_INT, E_NONE, tok_line, tok_start, tok_len); open_token(c);
        end
      SC_IDENT:
        if (alpha_c(c) || digit_c(c) || c == CH_UNDER) begin
          if (tok_len != 16'hFFFF) tok_len++;
          window = {window[47:0], c};
        end else begin
          close_word(); open_token(c);
        end
      SC_SLASH:
        if (c == CH_SLASH) mode = SC_LINEC;
        else if (c == CH_STAR) mode = SC_BLOCK;
        else begin
          push_token(K_SLASH, E_NONE, tok_line, tok_start, 16'd1); open_token(c);
        end
      SC_LINEC: if (c == CH_LF) mode = SC_IDLE;
      SC_BLOCK: if (c == CH_STAR) mode = SC_BSTAR;
      SC_BSTAR:
        if (c == CH_SLASH) mode = SC_IDLE;
        else if (c != CH_STAR) mode = SC_BLOCK;
      SC_HELD:
        if (pk != K_END) begin
          push_token(pk, E_NONE, tok_line, tok_start, 16'd2); mode = SC_IDLE;
        end else begin
          close_held();
          if (mode == SC_IDLE) open_token(c);
        end
      SC_DROP: ;
      default: open_token(c);
    endcase
    if (c == CH_LF && line_cnt != 16'hFFFF) line_cnt++;
    if (offset != 24'hFFFFFF) offset++;
  endtask

  task automatic scan_end();
    case (mode)
      SC_INT:   push_token(K_INT, E_NONE, tok_line, tok_start, tok_len);
      SC_IDENT: close_word();
      SC_SLASH: push_token(K_SLASH, E_NONE, tok_line, tok_start, 16'd1);
      SC_HELD:  close_held();
      default: ;
    endcase
    push_token(K_END, E_NONE, line_cnt, offset, 16'd0);
    clear_scan();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    token_t want, got;
    if (!rst_ni) begin
      clear_scan();
      token_queue.delete();
      fails = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{token_kind_i, error_code_i, token_line_i, token_start_i,
                token_length_i, last_result_i};
        if (token_queue.size() == 0) begin
          $display("%0t: unexpected token, expected none actual %p", $time, got);
          fails++;
        end else begin
          want = token_queue.pop_front();
          if (got !== want) begin
            $display("%0t: token mismatch, expected %p actual %p", $time, want, got);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        step_tokens.delete();
        if (byte_present_i) scan_byte(source_byte_i);
        if (end_of_source_i) scan_end();
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
        token_queue = {token_queue, step_tokens};
      end
    end
  end

endmodule

### test/token_lexer_test.sv
// ----------------------------------------------------------------------------
// token_lexer_test
// drives source texts into the lexer with random gaps and output stalls;
// a checker beside the block predicts every token and compares
// ----------------------------------------------------------------------------
module token_lexer_test;
  import tlx_pkg::*;

  logic              clk, rst_n;
  logic              in_valid, in_stall, out_valid, out_stall;
  logic [7:0]        src_byte;
  logic              byte_present, end_of_source;
  logic [KIND_W-1:0] token_kind;
  logic [ERR_W-1:0]  error_code;
  logic [15:0]       token_line, token_length;
  logic [23:0]       token_start;
  logic              last_result;
  int                fail_count, pending_tokens;
  int                send_idle_pct, recv_idle_pct;
  int                cycles = 0;
  int                sent;

  token_lexer u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .source_byte_i(src_byte), .byte_present_i(byte_present),
    .end_of_source_i(end_of_source),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .token_kind_o(token_kind), .error_code_o(error_code),
    .token_line_o(token_line), .token_start_o(token_start),
    .token_length_o(token_length), .last_result_o(last_result)
  );

  token_lexer_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .source_byte_i(src_byte), .byte_present_i(byte_present),
    .end_of_source_i(end_of_source),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .token_kind_i(token_kind), .error_code_i(error_code),
    .token_line_i(token_line), .token_start_i(token_start),
    .token_length_i(token_length), .last_result_i(last_result),
    .fail_count_o(fail_count), .pending_tokens_o(pending_tokens)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: ends the run as failed, far above the length of any correct run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stalls at random at the current rate
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // one input transaction; random gaps before it, held until accepted
  task automatic send_item(logic [7:0] b, logic pres, logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    src_byte <= b;
    byte_present <= pres;
    end_of_source <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(string s, logic close);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b1, close && (i == s.len() - 1));
  endtask

  // one random byte, mostly lexically useful characters
  function automatic logic [7:0] pick_byte();
    string alphabet;
    alphabet = "aefilnoprstuvwxyz_AZ09 \n\t+-*/%(){};,!=<>&|";
    if ($urandom_range(99) < 6) return 8'($urandom_range(255));
    return alphabet[$urandom_range(alphabet.len() - 1)];
  endfunction

  // a random source text built from well-formed fragments plus some noise
  task automatic send_source();
    string frags [18];
    int    n;
    frags = '{"func ", "var x1 ", "if ", "else ", "while(", "for ", "return 42;",
              "print ", "a!=b ", "c==d ", "e<=f ", "g>=h ", "p&&q ", "r||s ",
              "// note\n", "/* blk ** x */", "_id9 = 7 ", "{x,y}%z-1*2\n"};
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1: send_item(pick_byte(), 1'b1, 1'b0);
        2:    send_item(pick_byte(), 1'b0, 1'b0);
        default: send_text(frags[$urandom_range(17)], 1'b0);
      endcase
    end
    // end of source with or without a last byte
    send_item(pick_byte(), 1'($urandom_range(1)), 1'b1);
  endtask

  initial begin
    sent = 0;
    send_idle_pct = 22;
    recv_idle_pct = 47;
    rst_n = 1'b0;
    in_valid = 1'b0;
    src_byte = '0;
    byte_present = 1'b0;
    end_of_source = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: keywords, operators, comments, held pairs and errors
    send_text("func var if else while for return print return1 ", 1'b0);
    send_text("+-*%(){};, != ! == = <= < >= > && ||\n", 1'b1);
    send_text("x/y // c\n/* a ** b */ 123 _Z9", 1'b1);
    send_text("a & b", 1'b1);
    send_text("|x", 1'b1);
    send_text("<", 1'b1);
    send_text("/", 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b1);
    send_item(8'h7F, 1'b0, 1'b0);
    send_item(8'h41, 1'b0, 1'b1);
    send_text("&", 1'b1);
    send_text("/* open", 1'b1);

    // random phases: receiver busy, sender busy, then full speed
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 47 : 0;
      recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 22 : 0;
      while (sent < 140 + (ph + 1) * 40) send_source();
    end
    in_valid <= 1'b0;

    while (pending_tokens != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
